>>> design/period_to_frequency_window_average_top_assert.svh
// Assertion macros for the period-to-frequency window averager.
`ifndef PERIOD_TO_FREQUENCY_WINDOW_AVERAGE_TOP_ASSERT_SVH
`define PERIOD_TO_FREQUENCY_WINDOW_AVERAGE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define P2F_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define P2F_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/p2f_pkg.sv
// Shared types and constants for the period-to-frequency window averager.
package p2f_pkg;

  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_W    = VAL_W + FRAC_W;
  localparam int unsigned SUM_W    = 38;
  localparam int unsigned FILL_W   = 6;
  localparam int unsigned CNT_W    = 6;
  localparam logic [CNT_W-1:0] DIV_LAST_STEP = CNT_W'(NUM_W - 1);

  // window average: long division by WINDOW, one 8-bit digit per cycle,
  // each digit found by a reciprocal multiply (exact for WINDOW up to 64)
  localparam int unsigned AVG_DIGIT_W = 8;
  localparam int unsigned AVG_STEPS   = 5;
  localparam int unsigned AVG_NUM_W   = AVG_DIGIT_W * AVG_STEPS;
  localparam int unsigned AVG_X_W     = FILL_W + AVG_DIGIT_W;
  localparam int unsigned AVG_SHIFT   = 20;
  localparam int unsigned AVG_CNT_W   = 3;
  localparam logic [AVG_CNT_W-1:0] AVG_LAST_STEP = AVG_CNT_W'(AVG_STEPS - 1);

  localparam logic [VAL_W-1:0] CLOCK_RESET = VAL_W'(84000000 / 2);

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] S_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] S_FREQ   = 3'd1;
  localparam logic [ST_W-1:0] S_ACC    = 3'd2;
  localparam logic [ST_W-1:0] S_AVG_LD = 3'd3;
  localparam logic [ST_W-1:0] S_AVG    = 3'd4;
  localparam logic [ST_W-1:0] S_FIN    = 3'd5;
  localparam logic [ST_W-1:0] S_EMIT   = 3'd6;

  typedef struct packed {
    logic cal_load;
    logic freq_load;
    logic avg_load;
    logic div_step;
    logic avg_step;
    logic acc;
    logic avg_done;
    logic out_load;
  } p2f_cmd_t;

  typedef struct packed {
    logic              div_last;
    logic              avg_last;
    logic              win_last;
    logic [FILL_W-1:0] window_fill;
  } p2f_status_t;

endpackage

>>> design/p2f_if.sv
// Handshake channels: period/calibration input and average result.
interface p2f_in_if;
  import p2f_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [VAL_W-1:0] value;
  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface p2f_out_if;
  import p2f_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] avg_freq;
  logic [VAL_W-1:0] clock_rate;
  logic             from_calibration;
  modport source (output valid, output avg_freq, output clock_rate,
                  output from_calibration, input ready);
  modport sink   (input valid, input avg_freq, input clock_rate,
                  input from_calibration, output ready);
endinterface

>>> design/p2f_datapath.sv
// Datapath: clock rate, bit-serial divider, window sum, average divider and result register.
module p2f_datapath
  import p2f_pkg::*;
#(
  parameter int unsigned WINDOW = 50
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [VAL_W-1:0] in_value,
  input  p2f_cmd_t         cmd,
  output p2f_status_t      status,
  output logic [VAL_W-1:0] out_avg_freq,
  output logic [VAL_W-1:0] out_clock_rate,
  output logic             out_from_calibration
);

  localparam logic [AVG_SHIFT:0] AVG_RECIP =
    (AVG_SHIFT+1)'(((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW);

  logic [VAL_W-1:0]  clock_count_r;
  logic [SUM_W-1:0]  window_sum_r;
  logic [FILL_W-1:0] window_fill_r;
  logic [VAL_W-1:0]  held_average_r;
  logic              cal_flag_r;

  logic [NUM_W-1:0]  div_num_r;
  logic [VAL_W-1:0]  div_rem_r;
  logic [VAL_W-1:0]  div_den_r;
  logic [CNT_W-1:0]  div_cnt_r;

  logic [AVG_NUM_W-1:0] avg_num_r;
  logic [FILL_W-1:0]    avg_rem_r;
  logic [AVG_CNT_W-1:0] avg_cnt_r;

  logic [VAL_W-1:0]  avg_r;
  logic [VAL_W-1:0]  rate_r;
  logic              from_cal_r;

  logic [VAL_W:0]    trial;
  logic              trial_ge;
  logic [VAL_W-1:0]  quot_sat;
  logic [FILL_W:0]   fill_inc;

  logic [AVG_X_W-1:0]         avg_x;
  logic [AVG_X_W+AVG_SHIFT:0] avg_prod;
  logic [AVG_DIGIT_W-1:0]     avg_digit;
  logic [AVG_X_W-1:0]         avg_back;
  logic [AVG_X_W-1:0]         avg_left;
  logic [VAL_W-1:0]           avg_sat;

  // one restoring step: shift in the next numerator bit, subtract if it fits
  assign trial    = {div_rem_r, div_num_r[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, div_den_r});
  // zero divisor gives an all-ones quotient, so it saturates here too
  assign quot_sat = (|div_num_r[NUM_W-1:VAL_W]) ? {VAL_W{1'b1}} : div_num_r[VAL_W-1:0];
  assign fill_inc = {1'b0, window_fill_r} + (FILL_W+1)'(1);

  // remainder stays below WINDOW, so each digit fits in 8 bits
  assign avg_x     = {avg_rem_r, avg_num_r[AVG_NUM_W-1 -: AVG_DIGIT_W]};
  assign avg_prod  = {{(AVG_SHIFT+1){1'b0}}, avg_x} * {{AVG_X_W{1'b0}}, AVG_RECIP};
  assign avg_digit = avg_prod[AVG_SHIFT +: AVG_DIGIT_W];
  assign avg_back  = {{FILL_W{1'b0}}, avg_digit} * AVG_X_W'(WINDOW);
  assign avg_left  = avg_x - avg_back;
  assign avg_sat   = (|avg_num_r[AVG_NUM_W-1:VAL_W]) ? {VAL_W{1'b1}} : avg_num_r[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_count_r  <= CLOCK_RESET;
      window_sum_r   <= '0;
      window_fill_r  <= '0;
      held_average_r <= '0;
    end else begin
      if (cmd.cal_load) begin
        clock_count_r <= in_value;
      end
      if (cmd.acc) begin
        window_sum_r  <= window_sum_r + {{(SUM_W-VAL_W){1'b0}}, quot_sat};
        window_fill_r <= fill_inc[FILL_W-1:0];
      end
      if (cmd.avg_done) begin
        held_average_r <= avg_sat;
        window_sum_r   <= '0;
        window_fill_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cal_load) begin
      cal_flag_r <= 1'b1;
    end else if (cmd.freq_load) begin
      cal_flag_r <= 1'b0;
    end
    if (cmd.freq_load) begin
      div_num_r <= {clock_count_r, {FRAC_W{1'b0}}};
      div_den_r <= in_value;
      div_rem_r <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_num_r <= {div_num_r[NUM_W-2:0], trial_ge};
      div_rem_r <= trial_ge ? VAL_W'(trial - {1'b0, div_den_r}) : trial[VAL_W-1:0];
      div_cnt_r <= div_cnt_r + CNT_W'(1);
    end
    // sum digits shift out at the top, quotient digits shift in at the bottom
    if (cmd.avg_load) begin
      avg_num_r <= {{(AVG_NUM_W-SUM_W){1'b0}}, window_sum_r};
      avg_rem_r <= '0;
      avg_cnt_r <= '0;
    end else if (cmd.avg_step) begin
      avg_num_r <= {avg_num_r[AVG_NUM_W-AVG_DIGIT_W-1:0], avg_digit};
      avg_rem_r <= avg_left[FILL_W-1:0];
      avg_cnt_r <= avg_cnt_r + AVG_CNT_W'(1);
    end
    if (cmd.out_load) begin
      avg_r      <= held_average_r;
      rate_r     <= clock_count_r;
      from_cal_r <= cal_flag_r;
    end
  end

  assign status.div_last    = (div_cnt_r == DIV_LAST_STEP);
  assign status.avg_last    = (avg_cnt_r == AVG_LAST_STEP);
  assign status.win_last    = (fill_inc >= (FILL_W+1)'(WINDOW));
  assign status.window_fill = window_fill_r;

  assign out_avg_freq         = avg_r;
  assign out_clock_rate       = rate_r;
  assign out_from_calibration = from_cal_r;

endmodule

>>> design/p2f_ctrl.sv
// Controller: sequences the divides, window update and result hand-off.
module p2f_ctrl
  import p2f_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  p2f_status_t     status,
  output p2f_cmd_t        cmd,
  output logic [ST_W-1:0] state
);

  logic [ST_W-1:0] state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op) begin
            cmd.cal_load = 1'b1;
            state_nxt    = S_EMIT;
          end else begin
            cmd.freq_load = 1'b1;
            state_nxt     = S_FREQ;
          end
        end
      end
      S_FREQ: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = status.win_last ? S_AVG_LD : S_IDLE;
      end
      S_AVG_LD: begin
        cmd.avg_load = 1'b1;
        state_nxt    = S_AVG;
      end
      S_AVG: begin
        cmd.avg_step = 1'b1;
        if (status.avg_last) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.avg_done = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign state     = state_r;

endmodule

>>> design/period_to_frequency_window_average_top.sv
// Period-to-frequency converter with block average over WINDOW samples.
// A period beat (op 0) is turned into a Q16.16 frequency, clock_rate * 2^16 / period,
// by a bit-serial restoring divider that retires one quotient bit per cycle, 48 in all;
// a zero period or a quotient above 32 bits saturates to all ones. The frequency is added
// to the window sum, and the beat that completes the window starts a five-digit divide
// of the sum by WINDOW (one 8-bit digit per cycle by reciprocal multiply), whose result
// is sent out and kept as the held average.
// A calibration beat (op 1) loads a new clock rate and sends the held average, with no divide.
// Input beats are taken one at a time: a period beat holds the block through its divide
// and window update, and the average divide when it closes the window. The result sits in an
// output register, so the next beat is taken while it waits; a further result waits
// for that register to drain. Clock rate resets to 42000000 ticks per second.
`include "period_to_frequency_window_average_top_assert.svh"

module period_to_frequency_window_average_top
  import p2f_pkg::*;
#(
  parameter int unsigned WINDOW = 50
) (
  input logic      clk,
  input logic      rst_n,
  p2f_in_if.sink   in_ch,
  p2f_out_if.source out_ch
);

  p2f_cmd_t        cmd;
  p2f_status_t     status;
  logic [ST_W-1:0] state;

  p2f_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .state     (state)
  );

  p2f_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_value             (in_ch.value),
    .cmd                  (cmd),
    .status               (status),
    .out_avg_freq         (out_ch.avg_freq),
    .out_clock_rate       (out_ch.clock_rate),
    .out_from_calibration (out_ch.from_calibration)
  );

  `P2F_ASSERT_NXT(a_cal_goes_to_emit, in_ch.valid && in_ch.ready && in_ch.op, state == S_EMIT, "calibration beat did not go straight to result hand-off")
  `P2F_ASSERT_NXT(a_emit_sets_valid, state == S_EMIT && (!out_ch.valid || out_ch.ready), out_ch.valid && state == S_IDLE, "result not presented after hand-off")
  `P2F_ASSERT_IMP(a_fill_bounded, 1'b1, status.window_fill <= FILL_W'(WINDOW), "window fill passed WINDOW")

endmodule
